FILE: src/flt_pkg.sv
// Shared types and constants for the failed-attempt lockout table.
package flt_pkg;

  localparam int AddrWidth  = 32;
  localparam int TimeWidth  = 32;
  localparam int CountWidth = 8;
  localparam int CfgWidth   = 16;
  localparam int CfgIdxWidth = 2;

  // Input operation codes
  localparam logic OP_CHECK  = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  // Verdict codes
  localparam logic [1:0] VERDICT_OK     = 2'd0;
  localparam logic [1:0] VERDICT_LOCKED = 2'd1;
  localparam logic [1:0] VERDICT_WAIT   = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxWidth-1:0] CFG_LOCK_THRESHOLD     = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_LOCK_WINDOW        = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_SHORT_WINDOW       = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_SHORT_CHECK_ENABLE = 2'd3;

  // Configuration reset values
  localparam logic [7:0]  RST_LOCK_THRESHOLD     = 8'd3;
  localparam logic [15:0] RST_LOCK_WINDOW        = 16'd900;
  localparam logic [15:0] RST_SHORT_WINDOW       = 16'd15;
  localparam logic        RST_SHORT_CHECK_ENABLE = 1'b1;

  localparam logic [CountWidth-1:0] COUNT_MAX = 8'd255;

  typedef struct packed {
    logic                 op;
    logic [AddrWidth-1:0] addr;
    logic                 failed;
    logic [TimeWidth-1:0] now;
  } item_t;

  typedef struct packed {
    logic [7:0]  lock_threshold;
    logic [15:0] lock_window;
    logic [15:0] short_window;
    logic        short_check_enable;
  } cfg_t;

endpackage

FILE: src/flt_in_stage.sv
// Input register stage: holds one accepted transaction until the table takes it.
module flt_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  flt_pkg::item_t item_in,
  input  logic          advance,
  output logic          stage_valid,
  output flt_pkg::item_t item
);
  import flt_pkg::*;

  logic valid;

  assign in_ready    = !valid || advance;
  assign stage_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_in;
    end
  end

endmodule

FILE: src/flt_table.sv
// Associative address table with LRU ranks, failure counts and verdict logic.
module flt_table #(
  parameter int ENTRIES = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  flt_pkg::item_t item,
  input  flt_pkg::cfg_t  cfg,
  output logic [1:0]     verdict
);
  import flt_pkg::*;

  localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [RW-1:0] RANK_LAST = RW'(ENTRIES - 1);

  logic [ENTRIES-1:0]    valid;
  logic [RW-1:0]         rank       [ENTRIES];
  logic [AddrWidth-1:0]  entry_addr [ENTRIES];
  logic [CountWidth-1:0] fail_count [ENTRIES];
  logic [TimeWidth-1:0]  fail_time  [ENTRIES];

  logic          hit_any, free_any, mru_any;
  logic [RW-1:0] hit_idx, free_idx, last_idx, mru_idx, tgt;
  logic          is_check, fill_new, do_write;
  logic [CountWidth-1:0] cnt, cnt_next;
  logic [TimeWidth-1:0]  elapsed;

  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    mru_any  = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    last_idx = '0;
    mru_idx  = '0;
    for (int j = 0; j < ENTRIES; j++) begin
      if (valid[j] && entry_addr[j] == item.addr && !hit_any) begin
        hit_any = 1'b1;
        hit_idx = RW'(j);
      end
      if (!valid[j] && !free_any) begin
        free_any = 1'b1;
        free_idx = RW'(j);
      end
      if (valid[j] && rank[j] == RANK_LAST) begin
        last_idx = RW'(j);
      end
      if (valid[j] && rank[j] == '0 && !mru_any) begin
        mru_any = 1'b1;
        mru_idx = RW'(j);
      end
    end
  end

  assign is_check = (item.op == OP_CHECK);
  assign fill_new = is_check && !hit_any && free_any;

  always_comb begin
    if (!is_check) begin
      tgt = mru_idx;
    end else if (hit_any) begin
      tgt = hit_idx;
    end else if (free_any) begin
      tgt = free_idx;
    end else begin
      tgt = last_idx;
    end
  end

  assign cnt     = fail_count[tgt];
  assign elapsed = item.now - fail_time[tgt];

  always_comb begin
    verdict = VERDICT_OK;
    if (hit_any) begin
      if (cnt >= cfg.lock_threshold) begin
        if (elapsed <= {16'b0, cfg.lock_window}) begin
          verdict = VERDICT_LOCKED;
        end
      end else if (cfg.short_check_enable && cnt != '0) begin
        if (elapsed <= {16'b0, cfg.short_window}) begin
          verdict = VERDICT_WAIT;
        end
      end
    end
  end

  // Saturate on failure, clear on success
  always_comb begin
    if (item.failed) begin
      cnt_next = (cnt == COUNT_MAX) ? cnt : cnt + 8'd1;
    end else begin
      cnt_next = '0;
    end
  end

  assign do_write = fire && (is_check ? !hit_any : mru_any);

  always_ff @(posedge clk) begin
    if (do_write) begin
      fail_time[tgt] <= item.now;
      if (is_check) begin
        entry_addr[tgt] <= item.addr;
        fail_count[tgt] <= '0;
      end else begin
        fail_count[tgt] <= cnt_next;
      end
    end
  end

  // Move the target to the front; entries ahead of it drop back one place
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      for (int j = 0; j < ENTRIES; j++) begin
        rank[j] <= '0;
      end
    end else if (fire && is_check) begin
      for (int j = 0; j < ENTRIES; j++) begin
        if (RW'(j) == tgt) begin
          rank[j]  <= '0;
          valid[j] <= 1'b1;
        end else if (valid[j] && (fill_new || rank[j] < rank[tgt])) begin
          rank[j] <= rank[j] + RW'(1);
        end
      end
    end
  end

endmodule

FILE: src/failed_attempt_lockout_table_unit.sv
// Top level of the failed-attempt lockout table.
//
//  channel | signals                          | direction | carries
//  in      | in_valid/in_ready, op..now       | into      | check or report transaction
//  out     | out_valid/out_ready, verdict     | out of    | one verdict per check
//  cfg     | cfg_we, cfg_index, cfg_data      | into      | register write, no wait
//
// A transaction is registered on acceptance and resolved against the table as it leaves the
// input register into the verdict register; one transaction per cycle unless a verdict stalls.
// The table lookup, LRU rank update and verdict compare sit between the input
// register and the verdict register. Reports produce no verdict and never stall.
// A stalled verdict holds the input register; rst empties the table, drops pending items and reloads cfg.
module failed_attempt_lockout_table_unit #(
  parameter int ENTRIES = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                op,
  input  logic [flt_pkg::AddrWidth-1:0]       addr,
  input  logic                                failed,
  input  logic [flt_pkg::TimeWidth-1:0]       now,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          verdict,
  input  logic                                cfg_we,
  input  logic [flt_pkg::CfgIdxWidth-1:0]     cfg_index,
  input  logic [flt_pkg::CfgWidth-1:0]        cfg_data
);
  import flt_pkg::*;

  item_t      item_in, item;
  cfg_t       cfg;
  logic       stage_valid, advance;
  logic [1:0] table_verdict;

  assign item_in = '{op: op, addr: addr, failed: failed, now: now};

  // Reports need no output slot
  assign advance = stage_valid && (item.op == OP_REPORT || !out_valid || out_ready);

  flt_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .item_in    (item_in),
    .advance    (advance),
    .stage_valid(stage_valid),
    .item       (item)
  );

  flt_table #(.ENTRIES(ENTRIES)) u_table (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (item),
    .cfg    (cfg),
    .verdict(table_verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lock_threshold     <= RST_LOCK_THRESHOLD;
      cfg.lock_window        <= RST_LOCK_WINDOW;
      cfg.short_window       <= RST_SHORT_WINDOW;
      cfg.short_check_enable <= RST_SHORT_CHECK_ENABLE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOCK_THRESHOLD:     cfg.lock_threshold     <= cfg_data[7:0];
        CFG_LOCK_WINDOW:        cfg.lock_window        <= cfg_data;
        CFG_SHORT_WINDOW:       cfg.short_window       <= cfg_data;
        CFG_SHORT_CHECK_ENABLE: cfg.short_check_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && item.op == OP_CHECK) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item.op == OP_CHECK) begin
      verdict <= table_verdict;
    end
  end

endmodule

FILE: src/flt_checker.sv
// Port-level checker for the lockout table, bound to the top level.
module flt_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] verdict
);
  import flt_pkg::*;

  // Hold a stalled verdict
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(verdict))
    else $error("verdict changed while stalled");

  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (verdict == VERDICT_OK || verdict == VERDICT_LOCKED ||
                   verdict == VERDICT_WAIT))
    else $error("verdict carries an unused code");

  // With the output slot empty the input stage always drains
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result pending right after reset");

endmodule

bind failed_attempt_lockout_table_unit flt_checker u_flt_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .verdict  (verdict)
);
